### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the standard deviation engine.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active (low).
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active (low).
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/psd_pkg.sv
// Package for the population standard deviation engine: widths, FSM states,
// shared-unit control types. No dependencies.
package psd_pkg;

    localparam int MAX_SAMPLES = 512;
    localparam int SMP_W       = 24;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int SUM_W       = SMP_W + CNT_W;
    localparam int SQ_W        = 2 * SMP_W;
    localparam int DEV_W       = 2 * SMP_W + CNT_W + 1;
    localparam int SQ_STEPS    = (DEV_W + 1) / 2;
    localparam int STEP_W      = $clog2(DEV_W);
    localparam int OUT_CNT_W   = 10;
    localparam int OUT_DATA_W  = ((SMP_W + OUT_CNT_W + 7) / 8) * 8;
    localparam int IN_DATA_W   = ((SMP_W + 7) / 8) * 8;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_WAIT,
        S_PASS,
        S_VAR_WAIT,
        S_ROOT_WAIT,
        S_EMIT
    } t_state;

endpackage

### hdl/psd_unit.sv
// Shared iterative arithmetic unit: restoring divide (one quotient bit per cycle)
// and digit-by-digit integer square root (one result bit per cycle).
// Depends on psd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psd_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psd_pkg::t_unit_req       i_req,
    input  logic [psd_pkg::DEV_W-1:0] i_a,
    input  logic [psd_pkg::CNT_W-1:0] i_b,
    output psd_pkg::t_unit_rsp       o_rsp,
    output logic [psd_pkg::DEV_W-1:0] o_result
);

    logic                       r_busy;
    logic                       r_done;
    psd_pkg::t_unit_op          r_op;
    logic [psd_pkg::STEP_W-1:0] r_step;
    logic [psd_pkg::DEV_W-1:0]  r_x;
    logic [psd_pkg::DEV_W-1:0]  r_res;
    logic [psd_pkg::DEV_W-1:0]  r_bit;
    logic [psd_pkg::CNT_W-1:0]  r_rem;
    logic [psd_pkg::CNT_W-1:0]  r_b;

    logic [psd_pkg::CNT_W:0]    trial;
    logic [psd_pkg::DEV_W:0]    lhs;
    logic [psd_pkg::DEV_W:0]    rhs;
    logic [psd_pkg::DEV_W:0]    diff;
    logic                       ge;

    // one shared subtract/compare serves both operations
    always_comb begin
        trial = {r_rem, r_x[psd_pkg::DEV_W-1]};
        if (r_op == psd_pkg::OP_DIV) begin
            lhs = (psd_pkg::DEV_W + 1)'(trial);
            rhs = (psd_pkg::DEV_W + 1)'(r_b);
        end else begin
            lhs = {1'b0, r_x};
            rhs = {1'b0, r_res + r_bit};
        end
        diff = lhs - rhs;
        ge   = !diff[psd_pkg::DEV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= psd_pkg::OP_DIV;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_step <= (i_req.op == psd_pkg::OP_DIV) ?
                          psd_pkg::STEP_W'(psd_pkg::DEV_W - 1) :
                          psd_pkg::STEP_W'(psd_pkg::SQ_STEPS - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_a;
            r_b   <= i_b;
            r_rem <= '0;
            r_res <= '0;
            r_bit <= psd_pkg::DEV_W'(1) << (2 * (psd_pkg::SQ_STEPS - 1));
        end else if (r_busy) begin
            if (r_op == psd_pkg::OP_DIV) begin
                r_rem <= ge ? diff[psd_pkg::CNT_W-1:0] : trial[psd_pkg::CNT_W-1:0];
                r_x   <= {r_x[psd_pkg::DEV_W-2:0], ge};
            end else begin
                if (ge) begin
                    r_x   <= diff[psd_pkg::DEV_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = (r_op == psd_pkg::OP_DIV) ? r_x : r_res;

    `ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_req.start, !r_busy)
    `ASSERT_NXT(a_div_no_zero, i_clk, i_rst_n,
                i_req.start && i_req.op == psd_pkg::OP_DIV, r_b != '0)
    `ASSERT_IMP(a_sqrt_bit_pow4, i_clk, i_rst_n,
                r_busy && r_op == psd_pkg::OP_SQRT, $onehot(r_bit))

endmodule

### hdl/population_std_dev_engine_top.sv
// Channel   | Dir | Fields (tdata/tuser low bit up)          | Handshake
// s_axis    | in  | tdata: sample[23:0]; tlast: last         | tvalid & tready
// m_axis    | out | tdata: std_dev[23:0], sample_count[33:24]; tuser: dropped
//
// Samples load at one item per cycle in the load state (tready is low otherwise) into a
// 512-entry store as the running sum updates. After the last item, a set takes two 59-step
// divides and a 30-step root on the shared unit, plus one store read per sample in the pass.
// A finished result waits in the output register; loading of the next set goes on,
// and the next result is held back only until that register is taken.
// Reset: synchronous, active low; the sample store itself is not cleared.
// Population standard deviation engine top level; depends on psd_pkg, psd_unit
// and assert_macros.svh.
`include "assert_macros.svh"

module population_std_dev_engine_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [psd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample[23:0]
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [psd_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // std_dev[23:0], sample_count[33:24]
    output logic                           m_axis_tuser   // dropped
);

    psd_pkg::t_state r_state, n_state;

    logic [psd_pkg::SMP_W-1:0]  r_mem [psd_pkg::MAX_SAMPLES];
    logic [psd_pkg::CNT_W-1:0]  r_count;
    logic [psd_pkg::SUM_W-1:0]  r_sum;
    logic [psd_pkg::DEV_W-1:0]  r_dev;
    logic                       r_ovf;
    logic [psd_pkg::SMP_W-1:0]  r_mean;
    logic [psd_pkg::CNT_W-1:0]  r_idx;
    logic                       r_rd_vld;
    logic [psd_pkg::SMP_W-1:0]  r_rd_data;
    logic                       r_sq_vld;
    logic [psd_pkg::SQ_W-1:0]   r_sq;
    logic [psd_pkg::SMP_W-1:0]  r_root;
    logic                       r_m_valid;
    logic [psd_pkg::SMP_W-1:0]  r_m_std;
    logic [psd_pkg::OUT_CNT_W-1:0] r_m_cnt;
    logic                       r_m_drop;

    psd_pkg::t_unit_req         unit_req;
    psd_pkg::t_unit_rsp         unit_rsp;
    logic [psd_pkg::DEV_W-1:0]  unit_a;
    logic [psd_pkg::DEV_W-1:0]  unit_res;

    logic                       in_acc;
    logic                       store_ok;
    logic [psd_pkg::SMP_W-1:0]  in_sample;
    logic [psd_pkg::SUM_W-1:0]  sum_abs;
    logic [psd_pkg::SMP_W-1:0]  mean_mag;
    logic                       issue;
    logic                       pass_done;
    logic                       emit;
    logic signed [psd_pkg::SMP_W:0]     dev;
    logic signed [2*psd_pkg::SMP_W+1:0] dev_prod;
    logic [psd_pkg::SMP_W-1:0]  root_sat;

    assign in_sample = s_axis_tdata[psd_pkg::SMP_W-1:0];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign store_ok  = r_count < psd_pkg::CNT_W'(psd_pkg::MAX_SAMPLES);
    assign sum_abs   = r_sum[psd_pkg::SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign mean_mag  = unit_res[psd_pkg::SMP_W-1:0];
    assign issue     = (r_state == psd_pkg::S_PASS) && (r_idx < r_count);
    assign pass_done = (r_idx == r_count) && !r_rd_vld && !r_sq_vld;
    assign dev       = $signed({r_rd_data[psd_pkg::SMP_W-1], r_rd_data})
                     - $signed({r_mean[psd_pkg::SMP_W-1], r_mean});
    assign dev_prod  = dev * dev;
    assign root_sat  = (|unit_res[psd_pkg::DEV_W-1:psd_pkg::SMP_W]) ? '1 :
                       unit_res[psd_pkg::SMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psd_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        s_axis_tready  = 1'b0;
        unit_req.start = 1'b0;
        unit_req.op    = psd_pkg::OP_DIV;
        unit_a         = psd_pkg::DEV_W'(sum_abs);
        emit           = 1'b0;
        case (r_state)
            psd_pkg::S_LOAD: begin
                s_axis_tready = 1'b1;
                if (in_acc && s_axis_tlast) begin
                    n_state = psd_pkg::S_MEAN;
                end
            end
            psd_pkg::S_MEAN: begin
                unit_req.start = 1'b1;
                n_state        = psd_pkg::S_MEAN_WAIT;
            end
            psd_pkg::S_MEAN_WAIT: begin
                if (unit_rsp.done) begin
                    n_state = psd_pkg::S_PASS;
                end
            end
            psd_pkg::S_PASS: begin
                unit_a = r_dev;
                if (pass_done) begin
                    unit_req.start = 1'b1;
                    n_state        = psd_pkg::S_VAR_WAIT;
                end
            end
            psd_pkg::S_VAR_WAIT: begin
                unit_a      = unit_res;
                unit_req.op = psd_pkg::OP_SQRT;
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    n_state        = psd_pkg::S_ROOT_WAIT;
                end
            end
            psd_pkg::S_ROOT_WAIT: begin
                if (unit_rsp.done) begin
                    n_state = psd_pkg::S_EMIT;
                end
            end
            psd_pkg::S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    emit    = 1'b1;
                    n_state = psd_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = psd_pkg::S_LOAD;
            end
        endcase
    end

    psd_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .i_a      (unit_a),
        .i_b      (r_count),
        .o_rsp    (unit_rsp),
        .o_result (unit_res)
    );

    // sample store
    always_ff @(posedge i_clk) begin
        if (in_acc && store_ok) begin
            r_mem[r_count[psd_pkg::ADDR_W-1:0]] <= in_sample;
        end
        r_rd_data <= r_mem[r_idx[psd_pkg::ADDR_W-1:0]];
    end

    // set accumulators and second-pass pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_dev    <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_sq_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_sq_vld <= r_rd_vld;
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_sq_vld) begin
                r_dev <= r_dev + psd_pkg::DEV_W'(r_sq);
            end
            if (in_acc) begin
                if (store_ok) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + {{(psd_pkg::SUM_W - psd_pkg::SMP_W){in_sample[psd_pkg::SMP_W-1]}},
                                        in_sample};
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (emit) begin
                r_count <= '0;
                r_sum   <= '0;
                r_dev   <= '0;
                r_ovf   <= 1'b0;
                r_idx   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_sq <= dev_prod[psd_pkg::SQ_W-1:0];
        end
        if (r_state == psd_pkg::S_MEAN_WAIT && unit_rsp.done) begin
            r_mean <= r_sum[psd_pkg::SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
        end
        if (r_state == psd_pkg::S_ROOT_WAIT && unit_rsp.done) begin
            r_root <= root_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_std  <= r_root;
            r_m_cnt  <= psd_pkg::OUT_CNT_W'(r_count);
            r_m_drop <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = psd_pkg::OUT_DATA_W'({r_m_cnt, r_m_std});
    assign m_axis_tuser  = r_m_drop;

    `ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1,
                r_count <= psd_pkg::CNT_W'(psd_pkg::MAX_SAMPLES))
    `ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, unit_rsp.done,
                r_state == psd_pkg::S_MEAN_WAIT || r_state == psd_pkg::S_VAR_WAIT ||
                r_state == psd_pkg::S_ROOT_WAIT)
    `ASSERT_IMP(a_set_cleared, i_clk, i_rst_n, $rose(m_axis_tvalid),
                r_count == '0 && !r_ovf && r_dev == '0)
    `ASSERT_IMP(a_pass_bound, i_clk, i_rst_n, 1'b1, r_idx <= r_count)

endmodule

### test/tb.sv
// Testbench for population_std_dev_engine_top: streams sample sets and checks the
// std_dev, sample_count and dropped flag of each set against an in-bench predictor.
// Depends on psd_pkg and the engine RTL.
module tb;

    localparam int SMP_W       = psd_pkg::SMP_W;
    localparam int CAPACITY    = psd_pkg::MAX_SAMPLES;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int END_WAIT    = 800;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        logic [23:0] std_dev;
        logic [9:0]  count;
        logic        dropped;
    } t_spread;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [psd_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // sample[23:0]
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [psd_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // std_dev[23:0], sample_count[33:24]
    logic                           m_axis_tuser;        // dropped

    // predictor state
    logic signed [SMP_W-1:0] held_samples [CAPACITY];
    int unsigned             held_count = 0;
    longint                  held_sum   = 0;
    bit                      held_spill = 1'b0;

    t_spread pending_spreads [$];
    int      err_count      = 0;
    int      send_idle_pct  = 0;
    bit      send_calm      = 1'b0;
    int      recv_stall_pct = 0;
    bit      rx_calm        = 1'b0;
    int      calm_left      = 0;
    int      hold_len       = 0;
    int      quiet_cycles   = 0;

    population_std_dev_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Folds one sample into the set; returns 1 with the set's spread on the last item.
    function automatic bit fold_sample(input logic signed [SMP_W-1:0] value, input bit last,
                                       output t_spread res);
        longint          mean;
        longint          d;
        longint unsigned dev_sum;
        longint unsigned var_q;
        longint unsigned root;
        res = '0;
        if (held_count < CAPACITY) begin
            held_samples[held_count] = value;
            held_count++;
            held_sum += value;
        end else begin
            held_spill = 1'b1;
        end
        if (!last) return 1'b0;
        mean = (held_count == 0) ? 0 : held_sum / longint'(held_count);
        dev_sum = 0;
        for (int i = 0; i < held_count; i++) begin
            d = longint'(held_samples[i]) - mean;
            dev_sum += longint'(d * d);
        end
        var_q = (held_count == 0) ? 0 : dev_sum / held_count;
        root = floor_root(var_q);
        if (root > 64'hFFFFFF) root = 64'hFFFFFF;
        res.std_dev = root[23:0];
        res.count   = held_count[9:0];
        res.dropped = held_spill;
        held_count = 0;
        held_sum   = 0;
        held_spill = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        err_count++;
    endtask

    task automatic take_result();
        t_spread want;
        if (pending_spreads.size() == 0) begin
            report_mismatch("unexpected result", 0, m_axis_tdata);
            return;
        end
        want = pending_spreads.pop_front();
        if (m_axis_tdata[23:0] !== want.std_dev)
            report_mismatch("std_dev", want.std_dev, m_axis_tdata[23:0]);
        if (m_axis_tdata[33:24] !== want.count)
            report_mismatch("sample_count", want.count, m_axis_tdata[33:24]);
        if (m_axis_tuser !== want.dropped)
            report_mismatch("dropped", want.dropped, m_axis_tuser);
    endtask

    // receiver: checks results, stalls at random outside calm stretches and hold-offs
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) take_result();
        m_axis_tready <= (hold_len == 0) &&
                         (rx_calm || ($urandom_range(99) >= recv_stall_pct));
    end

    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm_left <= $urandom_range(200, 20);
            rx_calm   <= ($urandom_range(3) == 0);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_len != 0) hold_len <= hold_len - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] value, input bit last);
        t_spread res;
        while (!send_calm && ($urandom_range(99) < send_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (fold_sample(value, last, res)) pending_spreads.push_back(res);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    task automatic drain();
        while (pending_spreads.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_list(input logic [SMP_W-1:0] vals [$]);
        for (int i = 0; i < vals.size(); i++) send_sample(vals[i], i == vals.size() - 1);
    endtask

    function automatic logic [SMP_W-1:0] pick_sample(input logic [SMP_W-1:0] center,
                                                      input int spread);
        int noise;
        case ($urandom_range(9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2, 3:    return SMP_W'($urandom);
            default: begin
                noise = int'($urandom_range(2 * spread, 0)) - spread;
                return 24'(int'(signed'(center)) + noise);
            end
        endcase
    endfunction

    task automatic send_random_set(input int size);
        logic [SMP_W-1:0] center;
        int               spread;
        center = SMP_W'($urandom);
        spread = 1 << $urandom_range(20);
        for (int k = 1; k <= size; k++) send_sample(pick_sample(center, spread), k == size);
    endtask

    task automatic test_directed();
        logic [SMP_W-1:0] vals [$];
        set_idling(0, 0);
        send_calm = 1'b1;
        vals = {24'h7FFFFF};
        send_list(vals);
        vals = {24'h800000};
        send_list(vals);
        vals = {24'h800000, 24'h7FFFFF};
        send_list(vals);
        // negative mean truncates toward zero
        vals = {24'hFFFFFD, 24'hFFFFFE, 24'hFFFFFE};
        send_list(vals);
        vals = {24'h000005, 24'h000005, 24'h000005, 24'h000005};
        send_list(vals);
        vals = {24'h000000, 24'h000001};
        send_list(vals);
        vals = {24'h123456, 24'h9ABCDF, 24'h000001, 24'hFFFFFF, 24'h0F0F0F};
        send_list(vals);
        stop_sending();
        drain();
    endtask

    task automatic test_capacity();
        set_idling(0, 0);
        send_calm = 1'b1;
        // exactly full, widest spread
        for (int k = 1; k <= CAPACITY; k++)
            send_sample((k % 2) ? 24'h800000 : 24'h7FFFFF, k == CAPACITY);
        // overflow; the last item itself is dropped
        send_random_set(CAPACITY + 3);
        stop_sending();
        drain();
    endtask

    task automatic test_hold_off();
        set_idling(0, 0);
        send_calm = 1'b1;
        hold_len <= HOLD_CYCLES;
        for (int s = 0; s < 6; s++) send_random_set(4);
        stop_sending();
        while (hold_len != 0) @(posedge i_clk);
        drain();
    endtask

    task automatic test_random();
        int sent;
        int pick;
        int size;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(49, 0);
                2:       set_idling(0, 49);
                default: set_idling(36, 36);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 80)      size = $urandom_range(24, 1);
                else if (pick < 97) size = $urandom_range(150, 25);
                else                size = $urandom_range(CAPACITY, 400);
                send_calm = ($urandom_range(3) == 0);
                send_random_set(size);
                sent += size;
            end
            stop_sending();
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_hold_off();
        test_random();
        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
